// ----- rtl/slwbc_pkg.sv -----
// ----------------------------------------------------------------------------
// slwbc_pkg
// Shared types and codes for the single-line write-back cache: request and
// response beat layouts, access modes, response kinds and default sizes.
// ----------------------------------------------------------------------------
package slwbc_pkg;

    // Fixed field widths of the request and response beats
    localparam int ADDR_FIELD_W = 8;
    localparam int BYTE_W       = 8;
    localparam int FILL_W       = 64;
    localparam int MODE_W       = 2;
    localparam int KIND_W       = 3;

    // Default geometry
    localparam int DEF_LINE_BYTES   = 8;
    localparam int DEF_ADDRESS_BITS = 8;

    // Access modes
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd3;

    // Response kinds
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STORE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITEBACK = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FETCH     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FLUSH     = 3'd4;

    // Request beat
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [ADDR_FIELD_W-1:0] address;
        logic [BYTE_W-1:0]       write_value;
        logic [FILL_W-1:0]       fill_line;
    } req_t;

    // Response beat
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [ADDR_FIELD_W-1:0] mem_address;
        logic [BYTE_W-1:0]       data;
        logic                    last;
    } rsp_t;

endpackage

// ----- rtl/slwbc_ram.sv -----
// ----------------------------------------------------------------------------
// slwbc_ram
// Generic single-write, single-read RAM with a registered read port. Read
// data holds until the next read is issued.
// ----------------------------------------------------------------------------
module slwbc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/slwbc_div.sv -----
// ----------------------------------------------------------------------------
// slwbc_div
// Splits a byte address into line number and byte offset. The line number
// comes from a multiply by the reciprocal of the line size and is registered;
// the offset is the registered address minus line number times line size.
// ----------------------------------------------------------------------------
module slwbc_div #(
    parameter int LINE_BYTES = 8,
    parameter int ADDR_W     = 8,
    parameter int LINE_W     = 5,
    parameter int OFF_W      = 3
) (
    input  logic              clk,
    input  logic              load,
    input  logic [ADDR_W-1:0] addr,
    output logic [LINE_W-1:0] quot,
    output logic [OFF_W-1:0]  rem
);

    // Exact for every address below 2**ADDR_W with ADDR_W <= 8
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + LINE_BYTES - 1) / LINE_BYTES;
    localparam int PROD_W      = ADDR_W + RECIP_SHIFT + 1;

    logic [PROD_W-1:0] prod;
    logic [ADDR_W-1:0] addr_reg;
    logic [LINE_W-1:0] quot_reg;
    logic [ADDR_W-1:0] rem_full;

    assign prod = PROD_W'(addr) * PROD_W'(RECIP);

    // Capture address and quotient
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= addr;
            quot_reg <= prod[RECIP_SHIFT +: LINE_W];
        end
    end

    // Recover the offset from the registered quotient
    assign rem_full = addr_reg - ADDR_W'(quot_reg) * ADDR_W'(LINE_BYTES);
    assign quot     = quot_reg;
    assign rem      = rem_full[OFF_W-1:0];

endmodule

// ----- rtl/single_line_write_back_cache.sv -----
// ----------------------------------------------------------------------------
// single_line_write_back_cache
// One cache line of LINE_BYTES bytes in front of a byte-addressed memory.
//
// Request channel (req_valid / req_stall / req): mode 0 reads, 1 writes,
// 2 delivers a fetched line, 3 flushes. Response channel (rsp_valid /
// rsp_stall / rsp) carries read data, store done, write-back bytes, line
// fetch requests and flush done; last marks the final beat of a request.
// One request is worked at a time: req_stall is high from the beat after
// acceptance until the final response beat is loaded, or until a fill that
// nothing waits for is dropped. A miss or flush scans the line byte by byte
// with one shared address adder, writes back each written byte, then sends
// a closing beat. A fill sweeps the line RAM one byte per cycle.
// The response register holds its beat while rsp_stall is high and the
// sequencer waits; a new request may be accepted while the last response
// still waits. Reset empties the line (nothing loaded, nothing written or
// pending); the line data RAM itself is not cleared.
// ----------------------------------------------------------------------------
module single_line_write_back_cache #(
    parameter int LINE_BYTES   = slwbc_pkg::DEF_LINE_BYTES,
    parameter int ADDRESS_BITS = slwbc_pkg::DEF_ADDRESS_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  slwbc_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output slwbc_pkg::rsp_t   rsp
);

    import slwbc_pkg::*;

    localparam int AW       = (ADDRESS_BITS < ADDR_FIELD_W) ? ADDRESS_BITS : ADDR_FIELD_W;
    localparam int LINE_W   = $clog2(((1 << AW) + LINE_BYTES - 1) / LINE_BYTES);
    localparam int OFF_W    = $clog2(LINE_BYTES);
    localparam int SUM_W    = AW + 1;
    localparam logic [OFF_W-1:0] IDX_LAST = OFF_W'(LINE_BYTES - 1);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_CHECK     = 9'b000000010,
        S_SCAN      = 9'b000000100,
        S_WB        = 9'b000001000,
        S_FINISH    = 9'b000010000,
        S_RDATA     = 9'b000100000,
        S_STORE     = 9'b001000000,
        S_FILL      = 9'b010000000,
        S_FILL_DONE = 9'b100000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [OFF_W-1:0]                idx_reg, idx_next;
    logic [LINE_W-1:0]               line_number_reg, line_number_next;
    logic                            loaded_reg, loaded_next;
    logic                            pending_reg, pending_next;
    logic                            pend_write_reg, pend_write_next;
    logic [OFF_W-1:0]                pend_off_reg, pend_off_next;
    logic [BYTE_W-1:0]               pend_value_reg, pend_value_next;
    logic [LINE_BYTES-1:0]           dirty_reg, dirty_next;

    logic [MODE_W-1:0]               mode_reg;
    logic [BYTE_W-1:0]               value_reg;
    logic [LINE_BYTES-1:0][BYTE_W-1:0] fill_reg;

    logic                            rsp_valid_reg;
    rsp_t                            rsp_reg;

    logic                            accept;
    logic                            out_free;
    logic                            emit;
    rsp_t                            emit_item;
    logic                            hit;

    logic [LINE_W-1:0]               div_q;
    logic [OFF_W-1:0]                div_r;

    logic                            ram_wr_en;
    logic [OFF_W-1:0]                ram_wr_addr;
    logic [BYTE_W-1:0]               ram_wr_data;
    logic                            ram_rd_en;
    logic [OFF_W-1:0]                ram_rd_addr;
    logic [BYTE_W-1:0]               ram_rd_data;

    logic [LINE_W-1:0]               unit_line;
    logic [OFF_W-1:0]                unit_off;
    logic [SUM_W-1:0]                unit_sum;
    logic [ADDR_FIELD_W-1:0]         unit_addr;

    // Handshake
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Address split
    slwbc_div #(
        .LINE_BYTES (LINE_BYTES),
        .ADDR_W     (AW),
        .LINE_W     (LINE_W),
        .OFF_W      (OFF_W)
    ) u_div (
        .clk  (clk),
        .load (accept),
        .addr (req.address[AW-1:0]),
        .quot (div_q),
        .rem  (div_r)
    );

    // Line data
    slwbc_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (LINE_BYTES),
        .ADDR_W (OFF_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Shared memory address unit: write-back byte or fetch base
    assign unit_line = (state_reg == S_FINISH) ? div_q : line_number_reg;
    assign unit_off  = (state_reg == S_FINISH) ? '0 : idx_reg;
    assign unit_sum  = SUM_W'(unit_line) * SUM_W'(LINE_BYTES) + SUM_W'(unit_off);
    assign unit_addr = ADDR_FIELD_W'(unit_sum[AW-1:0]);

    assign hit = loaded_reg && (div_q == line_number_reg);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        line_number_next = line_number_reg;
        loaded_next      = loaded_reg;
        pending_next     = pending_reg;
        pend_write_next  = pend_write_reg;
        pend_off_next    = pend_off_reg;
        pend_value_next  = pend_value_reg;
        dirty_next       = dirty_reg;
        emit             = 1'b0;
        emit_item        = '0;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = idx_reg;
        ram_wr_data      = fill_reg[idx_reg];
        ram_rd_en        = 1'b0;
        ram_rd_addr      = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                idx_next = '0;
                case (mode_reg) inside
                    MODE_READ, MODE_WRITE:
                    begin
                        if (!hit)
                        begin
                            state_next = S_SCAN;
                        end
                        else if (mode_reg == MODE_READ)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = div_r;
                            state_next  = S_RDATA;
                        end
                        else
                        begin
                            state_next = S_STORE;
                        end
                    end
                    MODE_FILL:
                    begin
                        // drop a fill that nothing waits for
                        state_next = pending_reg ? S_FILL : S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_SCAN;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (dirty_reg[idx_reg])
                begin
                    ram_rd_en  = 1'b1;
                    state_next = S_WB;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + OFF_W'(1);
                end
            end

            S_WB:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_item.kind        = KIND_WRITEBACK;
                    emit_item.mem_address = unit_addr;
                    emit_item.data        = ram_rd_data;
                    dirty_next[idx_reg]   = 1'b0;
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + OFF_W'(1);
                        state_next = S_SCAN;
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_item.last = 1'b1;
                    state_next     = S_IDLE;
                    if (mode_reg == MODE_FLUSH)
                    begin
                        emit_item.kind = KIND_FLUSH;
                    end
                    else
                    begin
                        // take the new line and wait for its fill
                        emit_item.kind        = KIND_FETCH;
                        emit_item.mem_address = unit_addr;
                        line_number_next      = div_q;
                        loaded_next           = 1'b0;
                        dirty_next            = '0;
                        pending_next          = 1'b1;
                        pend_write_next       = (mode_reg == MODE_WRITE);
                        pend_off_next         = div_r;
                        pend_value_next       = value_reg;
                    end
                end
            end

            S_RDATA:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_item.kind = KIND_READ;
                    emit_item.data = ram_rd_data;
                    emit_item.last = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_STORE:
            begin
                if (out_free)
                begin
                    ram_wr_en         = 1'b1;
                    ram_wr_addr       = div_r;
                    ram_wr_data       = value_reg;
                    dirty_next[div_r] = 1'b1;
                    emit              = 1'b1;
                    emit_item.kind    = KIND_STORE;
                    emit_item.last    = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            S_FILL:
            begin
                // sweep fetched bytes in, with the pending store merged
                ram_wr_en = 1'b1;
                if (pend_write_reg && (idx_reg == pend_off_reg))
                begin
                    ram_wr_data = pend_value_reg;
                end
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_FILL_DONE;
                end
                else
                begin
                    idx_next = idx_reg + OFF_W'(1);
                end
            end

            S_FILL_DONE:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_item.last = 1'b1;
                    loaded_next    = 1'b1;
                    pending_next   = 1'b0;
                    dirty_next     = '0;
                    state_next     = S_IDLE;
                    if (pend_write_reg)
                    begin
                        emit_item.kind           = KIND_STORE;
                        dirty_next[pend_off_reg] = 1'b1;
                    end
                    else
                    begin
                        emit_item.kind = KIND_READ;
                        emit_item.data = fill_reg[pend_off_reg];
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            line_number_reg <= '0;
            loaded_reg      <= 1'b0;
            pending_reg     <= 1'b0;
            pend_write_reg  <= 1'b0;
            pend_off_reg    <= '0;
            pend_value_reg  <= '0;
            dirty_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            line_number_reg <= line_number_next;
            loaded_reg      <= loaded_next;
            pending_reg     <= pending_next;
            pend_write_reg  <= pend_write_next;
            pend_off_reg    <= pend_off_next;
            pend_value_reg  <= pend_value_next;
            dirty_reg       <= dirty_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Capture request beat, load response beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= req.mode;
            value_reg <= req.write_value;
            fill_reg  <= req.fill_line[LINE_BYTES*BYTE_W-1:0];
        end
        if (emit)
        begin
            rsp_reg <= emit_item;
        end
    end

    // A final response beat always returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_item.last |=> state_reg == S_IDLE)
        else $error("sequencer not idle after final response beat");

    // A pending fetch and a loaded line exclude each other
    a_pending_unloaded: assert property (@(posedge clk) disable iff (!rst_n)
        !(pending_reg && loaded_reg))
        else $error("fetch pending while line loaded");

    // No written byte without a loaded line
    a_clean_unloaded: assert property (@(posedge clk) disable iff (!rst_n)
        !loaded_reg |-> dirty_reg == '0)
        else $error("written byte in an unloaded line");

endmodule
